// File: design/three_class_priority_queue_unit_assert.svh
// Assertion macros of the priority queue unit.
// Self-contained; compiled out when SYNTHESIS is defined.
`ifndef THREE_CLASS_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define THREE_CLASS_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TCPQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tcpq assertion failed");
`define TCPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcpq assertion failed");
`define TCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcpq assertion failed");
`else
`define TCPQ_ASSERT(label, clk, rst_n, prop)
`define TCPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/tcpq_pkg.sv
// Constants, codes and structs of the three-class priority queue.
// No dependencies; used by the interfaces, the queue unit, the class FIFO and the testbench.
package tcpq_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int NUM_CLASSES = 3;
	localparam int PTR_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W       = CNT_W + 2;
	localparam int CAP_W       = 6;
	localparam int CMP_W       = (TOT_W > CAP_W) ? TOT_W : CAP_W;
	localparam int CLOSE_W     = 3;
	localparam int OP_W        = 1;
	localparam int CAT_W       = 2;
	localparam int DUR_W       = 3;
	localparam int STATUS_W    = 3;
	localparam int OCC_W       = 6;
	localparam int SCNT_W      = 16;
	localparam int STIME_W     = 20;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(20);
	localparam logic [CLOSE_W-1:0] CLOSE_RESET = CLOSE_W'(3);
	localparam logic [CLOSE_W-1:0] PAUSE_MAX   = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ARRIVE = 1'b0,
		OP_SERVE  = 1'b1
	} op_t;

	typedef enum logic [CAT_W-1:0] {
		CAT_PAUSE    = 2'd0,
		CAT_OFFICER  = 2'd1,
		CAT_SERGEANT = 2'd2,
		CAT_CORPORAL = 2'd3
	} cat_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_PAUSE    = 3'd2,
		ST_CLOSED   = 3'd3,
		ST_SERVED   = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY = 2'd0,
		REG_CLOSING  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [DUR_W-1:0] data;
	} fifo_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [DUR_W-1:0]   head_dur;
		logic [SCNT_W-1:0]  served_nxt;
		logic [STIME_W-1:0] time_nxt;
	} fifo_stat_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CAT_W-1:0] category;
		logic [DUR_W-1:0] duration;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CAT_W-1:0]    served_category;
		logic [DUR_W-1:0]    served_duration;
		logic [OCC_W-1:0]    occupancy;
		logic                arrivals_closed;
		logic [SCNT_W-1:0]   class_served_count;
		logic [STIME_W-1:0]  class_service_time;
	} rsp_t;

endpackage

// File: design/tcpq_if.sv
// Valid/ready channel interfaces of the priority queue: request, result, config.
// Depends on tcpq_pkg for field widths.
interface tcpq_req_if;
	logic                           valid;
	logic                           ready;
	logic [tcpq_pkg::OP_W-1:0]      op;
	logic [tcpq_pkg::CAT_W-1:0]     category;
	logic [tcpq_pkg::DUR_W-1:0]     duration;
	modport source (output valid, op, category, duration, input ready);
	modport sink (input valid, op, category, duration, output ready);
endinterface

interface tcpq_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tcpq_pkg::STATUS_W-1:0]  status;
	logic [tcpq_pkg::CAT_W-1:0]     served_category;
	logic [tcpq_pkg::DUR_W-1:0]     served_duration;
	logic [tcpq_pkg::OCC_W-1:0]     occupancy;
	logic                           arrivals_closed;
	logic [tcpq_pkg::SCNT_W-1:0]    class_served_count;
	logic [tcpq_pkg::STIME_W-1:0]   class_service_time;
	modport source (output valid, status, served_category, served_duration, occupancy,
		arrivals_closed, class_served_count, class_service_time, input ready);
	modport sink (input valid, status, served_category, served_duration, occupancy,
		arrivals_closed, class_served_count, class_service_time, output ready);
endinterface

interface tcpq_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tcpq_pkg::CFG_IDX_W-1:0]    index;
	logic [tcpq_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/three_class_priority_queue_unit.sv
// Three-class strict-priority queue over three class FIFOs that share one capacity limit.
// The request is held in an input register and its result in a result register; the
// result register loads when it is empty or when its result is taken.
// Throughput: one item per cycle; the result register and the request register stall
// together only when the result is not taken.
// Reset clears pointers, counts, pause run, closed flag and totals; capacity 20, closing 3.
`include "three_class_priority_queue_unit_assert.svh"
module three_class_priority_queue_unit (
	input logic         clk,
	input logic         arst_n,
	tcpq_req_if.sink    req,
	tcpq_rsp_if.source  rsp,
	tcpq_cfg_if.sink    cfg
);

	tcpq_pkg::req_t                   req_s1;
	logic                             valid_s1;
	tcpq_pkg::rsp_t                   res_s2;
	logic                             res_valid_s2;

	logic [tcpq_pkg::CAP_W-1:0]       cap_q;
	logic [tcpq_pkg::CLOSE_W-1:0]     close_q;
	logic [tcpq_pkg::CLOSE_W-1:0]     pause_q;
	logic                             closed_q;

	tcpq_pkg::fifo_ctrl_t             ctrl [tcpq_pkg::NUM_CLASSES];
	tcpq_pkg::fifo_stat_t             stat [tcpq_pkg::NUM_CLASSES];

	logic                             adv;
	logic                             load;
	logic [tcpq_pkg::TOT_W-1:0]       occ_total;
	logic [tcpq_pkg::TOT_W-1:0]       occ_nxt;
	logic [tcpq_pkg::CMP_W-1:0]       eff_cap;
	logic                             room;
	logic [1:0]                       cls;
	logic                             do_push;
	logic                             do_pop;
	logic [tcpq_pkg::CLOSE_W-1:0]     pause_nxt;
	logic                             closed_nxt;
	tcpq_pkg::rsp_t                   res_nxt;
	logic [2*tcpq_pkg::NUM_CLASSES-1:0] fifo_act;

	assign adv       = valid_s1 && (!res_valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign load      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	for (genvar g = 0; g < tcpq_pkg::NUM_CLASSES; g++) begin : g_class
		tcpq_class_fifo u_fifo (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl[g]),
			.stat   (stat[g])
		);
		assign ctrl[g].push = adv && do_push && (cls == 2'(g));
		assign ctrl[g].pop  = adv && do_pop && (cls == 2'(g));
		assign ctrl[g].data = req_s1.duration;
		assign fifo_act[2*g]   = ctrl[g].push;
		assign fifo_act[2*g+1] = ctrl[g].pop;
	end

	assign occ_total = tcpq_pkg::TOT_W'(stat[0].count) + tcpq_pkg::TOT_W'(stat[1].count)
		+ tcpq_pkg::TOT_W'(stat[2].count);
	assign eff_cap = (tcpq_pkg::CMP_W'(cap_q) > tcpq_pkg::CMP_W'(tcpq_pkg::MAX_ENTRIES))
		? tcpq_pkg::CMP_W'(tcpq_pkg::MAX_ENTRIES) : tcpq_pkg::CMP_W'(cap_q);
	assign room = tcpq_pkg::CMP_W'(occ_total) < eff_cap;

	always_comb begin
		cls        = 2'd0;
		do_push    = 1'b0;
		do_pop     = 1'b0;
		pause_nxt  = pause_q;
		closed_nxt = closed_q;
		res_nxt    = '0;
		if (req_s1.op == tcpq_pkg::OP_ARRIVE) begin
			if (closed_q || (pause_q >= close_q)) begin
				closed_nxt     = 1'b1;
				res_nxt.status = tcpq_pkg::ST_CLOSED;
			end else if (req_s1.category == tcpq_pkg::CAT_PAUSE) begin
				pause_nxt = (pause_q == tcpq_pkg::PAUSE_MAX) ? pause_q : pause_q + 1'b1;
				if (pause_nxt >= close_q) begin
					closed_nxt = 1'b1;
				end
				res_nxt.status = tcpq_pkg::ST_PAUSE;
			end else begin
				pause_nxt = '0;
				cls       = req_s1.category - 2'd1;
				if (room && (stat[cls].count < tcpq_pkg::CNT_W'(tcpq_pkg::MAX_ENTRIES))) begin
					do_push        = 1'b1;
					res_nxt.status = tcpq_pkg::ST_ACCEPTED;
				end else begin
					res_nxt.status = tcpq_pkg::ST_DROPPED;
				end
			end
		end else begin
			if (stat[0].count != '0) begin
				cls    = 2'd0;
				do_pop = 1'b1;
			end else if (stat[1].count != '0) begin
				cls    = 2'd1;
				do_pop = 1'b1;
			end else if (stat[2].count != '0) begin
				cls    = 2'd2;
				do_pop = 1'b1;
			end
			if (do_pop) begin
				res_nxt.status             = tcpq_pkg::ST_SERVED;
				res_nxt.served_category    = cls + 2'd1;
				res_nxt.served_duration    = stat[cls].head_dur;
				res_nxt.class_served_count = stat[cls].served_nxt;
				res_nxt.class_service_time = stat[cls].time_nxt;
			end else begin
				res_nxt.status = tcpq_pkg::ST_EMPTY;
			end
		end
		occ_nxt = occ_total;
		if (do_push) begin
			occ_nxt = occ_total + 1'b1;
		end else if (do_pop) begin
			occ_nxt = occ_total - 1'b1;
		end
		res_nxt.occupancy       = occ_nxt[tcpq_pkg::OCC_W-1:0];
		res_nxt.arrivals_closed = closed_nxt;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1.op       <= req.op;
			req_s1.category <= req.category;
			req_s1.duration <= req.duration;
		end
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
			pause_q      <= '0;
			closed_q     <= 1'b0;
			cap_q        <= tcpq_pkg::CAP_RESET;
			close_q      <= tcpq_pkg::CLOSE_RESET;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_s2 <= 1'b1;
				pause_q      <= pause_nxt;
				closed_q     <= closed_nxt;
			end else if (rsp.ready) begin
				res_valid_s2 <= 1'b0;
			end
			if (cfg.valid && (cfg.index == tcpq_pkg::REG_CAPACITY)) begin
				cap_q <= cfg.data[tcpq_pkg::CAP_W-1:0];
			end
			if (cfg.valid && (cfg.index == tcpq_pkg::REG_CLOSING)) begin
				close_q <= cfg.data[tcpq_pkg::CLOSE_W-1:0];
			end
		end
	end

	assign rsp.valid              = res_valid_s2;
	assign rsp.status             = res_s2.status;
	assign rsp.served_category    = res_s2.served_category;
	assign rsp.served_duration    = res_s2.served_duration;
	assign rsp.occupancy          = res_s2.occupancy;
	assign rsp.arrivals_closed    = res_s2.arrivals_closed;
	assign rsp.class_served_count = res_s2.class_served_count;
	assign rsp.class_service_time = res_s2.class_service_time;

	`TCPQ_ASSERT(a_occ_bound, clk, arst_n, occ_total <= tcpq_pkg::TOT_W'(tcpq_pkg::MAX_ENTRIES))
	`TCPQ_ASSERT(a_one_fifo_op, clk, arst_n, $onehot0(fifo_act))
	`TCPQ_ASSERT_NEXT(a_closed_sticks, clk, arst_n, closed_q, closed_q)
	`TCPQ_ASSERT_NEXT(a_push_grows, clk, arst_n, adv && do_push, occ_total == $past(occ_total) + 1'b1)

endmodule

// File: design/tcpq_class_fifo.sv
// One class FIFO: entry store, head pointer, fill count and served totals.
// Depends on tcpq_pkg.
module tcpq_class_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcpq_pkg::fifo_ctrl_t ctrl,
	output tcpq_pkg::fifo_stat_t stat
);

	logic [tcpq_pkg::DUR_W-1:0]   slot_q [tcpq_pkg::MAX_ENTRIES];
	logic [tcpq_pkg::PTR_W-1:0]   head_q;
	logic [tcpq_pkg::CNT_W-1:0]   count_q;
	logic [tcpq_pkg::SCNT_W-1:0]  served_q;
	logic [tcpq_pkg::STIME_W-1:0] time_q;
	logic [tcpq_pkg::DUR_W-1:0]   head_dur_q;

	logic [tcpq_pkg::PTR_W:0]     tail_sum;
	logic [tcpq_pkg::PTR_W-1:0]   tail;
	logic [tcpq_pkg::PTR_W-1:0]   head_inc;
	logic [tcpq_pkg::STIME_W:0]   time_sum;

	assign tail_sum = {1'b0, head_q} + {1'b0, count_q[tcpq_pkg::PTR_W-1:0]};
	assign tail = (tail_sum >= (tcpq_pkg::PTR_W+1)'(tcpq_pkg::MAX_ENTRIES))
		? tcpq_pkg::PTR_W'(tail_sum - (tcpq_pkg::PTR_W+1)'(tcpq_pkg::MAX_ENTRIES))
		: tail_sum[tcpq_pkg::PTR_W-1:0];
	assign head_inc = (head_q == tcpq_pkg::PTR_W'(tcpq_pkg::MAX_ENTRIES - 1))
		? '0 : head_q + 1'b1;
	assign time_sum = {1'b0, time_q} + (tcpq_pkg::STIME_W+1)'(head_dur_q);

	always_comb begin
		stat.count      = count_q;
		stat.head_dur   = head_dur_q;
		stat.served_nxt = (served_q == '1) ? served_q : served_q + 1'b1;
		stat.time_nxt   = time_sum[tcpq_pkg::STIME_W] ? '1 : time_sum[tcpq_pkg::STIME_W-1:0];
	end

	// Hold the head entry in a register: load on a push into an empty FIFO,
	// advance to the next entry on a pop.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			slot_q[tail] <= ctrl.data;
			if (count_q == '0) begin
				head_dur_q <= ctrl.data;
			end
		end else if (ctrl.pop) begin
			head_dur_q <= slot_q[head_inc];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			served_q <= '0;
			time_q   <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop) begin
			head_q   <= head_inc;
			count_q  <= count_q - 1'b1;
			served_q <= stat.served_nxt;
			time_q   <= stat.time_nxt;
		end
	end

endmodule

// File: bench/three_class_priority_queue_unit_tb.sv
// Self-checking testbench of the three-class priority queue: a directed script, then
// random traffic in phases of idling, back-pressure and register settings.
// Depends on tcpq_pkg, the tcpq channel interfaces and three_class_priority_queue_unit.
module three_class_priority_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpq_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int TIME_CAP = (1 << STIME_W) - 1;
	localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = '1;

	typedef struct packed {
		logic                  is_cfg;
		op_t                   op;
		cat_t                  cat;
		logic [DUR_W-1:0]      dur;
		logic [CAP_W-1:0]      cap_val;
		logic [CLOSE_W-1:0]    close_val;
		logic                  typed;
		status_t               st;
		logic [OCC_W-1:0]      occ;
	} script_row_t;

	typedef struct packed {
		logic [CAP_W-1:0]   cap;
		logic [CLOSE_W-1:0] close;
		logic [6:0]         send_idle;
		logic [6:0]         stall;
		logic [9:0]         items;
		logic [6:0]         arrive;
		logic               hold;
		logic               allow_close;
	} phase_t;

	// is_cfg, op, cat, dur, cap_val, close_val, typed, st, occ
	localparam script_row_t SCRIPT [27] = '{
		'{1'b0, OP_SERVE,  CAT_PAUSE,    3'd0, 6'd0, 3'd0, 1'b1, ST_EMPTY,    6'd0},
		'{1'b0, OP_ARRIVE, CAT_OFFICER,  3'd7, 6'd0, 3'd0, 1'b1, ST_ACCEPTED, 6'd1},
		'{1'b0, OP_ARRIVE, CAT_SERGEANT, 3'd0, 6'd0, 3'd0, 1'b1, ST_ACCEPTED, 6'd2},
		'{1'b0, OP_ARRIVE, CAT_CORPORAL, 3'd5, 6'd0, 3'd0, 1'b1, ST_ACCEPTED, 6'd3},
		'{1'b0, OP_ARRIVE, CAT_OFFICER,  3'd3, 6'd0, 3'd0, 1'b1, ST_ACCEPTED, 6'd4},
		'{1'b0, OP_ARRIVE, CAT_PAUSE,    3'd6, 6'd0, 3'd0, 1'b1, ST_PAUSE,    6'd4},
		'{1'b0, OP_ARRIVE, CAT_PAUSE,    3'd1, 6'd0, 3'd0, 1'b1, ST_PAUSE,    6'd4},
		'{1'b0, OP_ARRIVE, CAT_CORPORAL, 3'd1, 6'd0, 3'd0, 1'b1, ST_ACCEPTED, 6'd5},
		'{1'b0, OP_ARRIVE, CAT_PAUSE,    3'd0, 6'd0, 3'd0, 1'b1, ST_PAUSE,    6'd5},
		'{1'b0, OP_ARRIVE, CAT_SERGEANT, 3'd6, 6'd0, 3'd0, 1'b1, ST_ACCEPTED, 6'd6},
		'{1'b0, OP_SERVE,  CAT_PAUSE,    3'd0, 6'd0, 3'd0, 1'b0, ST_SERVED,   6'd0},
		'{1'b0, OP_SERVE,  CAT_OFFICER,  3'd2, 6'd0, 3'd0, 1'b0, ST_SERVED,   6'd0},
		'{1'b0, OP_SERVE,  CAT_SERGEANT, 3'd4, 6'd0, 3'd0, 1'b0, ST_SERVED,   6'd0},
		'{1'b0, OP_SERVE,  CAT_CORPORAL, 3'd7, 6'd0, 3'd0, 1'b0, ST_SERVED,   6'd0},
		'{1'b0, OP_SERVE,  CAT_PAUSE,    3'd5, 6'd0, 3'd0, 1'b0, ST_SERVED,   6'd0},
		'{1'b0, OP_SERVE,  CAT_OFFICER,  3'd1, 6'd0, 3'd0, 1'b0, ST_SERVED,   6'd0},
		'{1'b0, OP_SERVE,  CAT_CORPORAL, 3'd7, 6'd0, 3'd0, 1'b1, ST_EMPTY,    6'd0},
		'{1'b1, OP_ARRIVE, CAT_PAUSE,    3'd0, 6'd0, 3'd2, 1'b0, ST_ACCEPTED, 6'd0},
		'{1'b0, OP_ARRIVE, CAT_OFFICER,  3'd4, 6'd0, 3'd0, 1'b1, ST_DROPPED,  6'd0},
		'{1'b0, OP_ARRIVE, CAT_PAUSE,    3'd3, 6'd0, 3'd0, 1'b1, ST_PAUSE,    6'd0},
		'{1'b0, OP_ARRIVE, CAT_CORPORAL, 3'd7, 6'd0, 3'd0, 1'b1, ST_DROPPED,  6'd0},
		'{1'b0, OP_ARRIVE, CAT_PAUSE,    3'd2, 6'd0, 3'd0, 1'b1, ST_PAUSE,    6'd0},
		'{1'b0, OP_ARRIVE, CAT_SERGEANT, 3'd2, 6'd0, 3'd0, 1'b1, ST_DROPPED,  6'd0},
		'{1'b1, OP_ARRIVE, CAT_PAUSE,    3'd0, 6'd1, 3'd2, 1'b0, ST_ACCEPTED, 6'd0},
		'{1'b0, OP_ARRIVE, CAT_CORPORAL, 3'd2, 6'd0, 3'd0, 1'b1, ST_ACCEPTED, 6'd1},
		'{1'b0, OP_ARRIVE, CAT_OFFICER,  3'd5, 6'd0, 3'd0, 1'b1, ST_DROPPED,  6'd1},
		'{1'b0, OP_SERVE,  CAT_PAUSE,    3'd0, 6'd0, 3'd0, 1'b0, ST_SERVED,   6'd0}
	};

	// cap, close, send_idle, stall, items, arrive, hold, allow_close
	localparam phase_t PHASES [8] = '{
		'{6'd63, 3'd7, 7'd0,  7'd0,  10'd110, 7'd75, 1'b0, 1'b0},
		'{6'd20, 3'd2, 7'd82, 7'd0,  10'd100, 7'd55, 1'b0, 1'b0},
		'{6'd1,  3'd4, 7'd0,  7'd82, 10'd90,  7'd50, 1'b0, 1'b0},
		'{6'd32, 3'd7, 7'd16, 7'd16, 10'd100, 7'd60, 1'b1, 1'b0},
		'{6'd0,  3'd3, 7'd82, 7'd82, 10'd60,  7'd50, 1'b0, 1'b0},
		'{6'd12, 3'd5, 7'd0,  7'd0,  10'd110, 7'd55, 1'b0, 1'b0},
		'{6'd32, 3'd1, 7'd16, 7'd16, 10'd100, 7'd65, 1'b0, 1'b0},
		'{6'd24, 3'd3, 7'd0,  7'd0,  10'd80,  7'd60, 1'b0, 1'b1}
	};

	logic clk;
	logic arst_n;

	tcpq_req_if req_ch();
	tcpq_rsp_if rsp_ch();
	tcpq_cfg_if cfg_ch();

	three_class_priority_queue_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic [DUR_W-1:0]   class_slot [NUM_CLASSES][MAX_ENTRIES];
	int                 class_head [NUM_CLASSES] = '{0, 0, 0};
	int                 class_depth [NUM_CLASSES] = '{0, 0, 0};
	logic [CLOSE_W-1:0] pause_streak = '0;
	logic               doors_shut = 1'b0;
	logic [SCNT_W-1:0]  served_tally [NUM_CLASSES] = '{'0, '0, '0};
	logic [STIME_W-1:0] time_tally [NUM_CLASSES] = '{'0, '0, '0};
	logic [CAP_W-1:0]   cap_setting = CAP_RESET;
	logic [CLOSE_W-1:0] close_setting = CLOSE_RESET;

	rsp_t pending_outcomes [$];
	rsp_t oldest_outcome;
	int   mismatches = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   hold_token = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	function automatic rsp_t queue_outcome(req_t it);
		rsp_t r;
		int   cls;
		int   held;
		int   lim;
		int   t;
		r = '0;
		cls = -1;
		held = class_depth[0] + class_depth[1] + class_depth[2];
		lim = (cap_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_setting);
		if (it.op == OP_ARRIVE) begin
			if (doors_shut || pause_streak >= close_setting) begin
				doors_shut = 1'b1;
				r.status = ST_CLOSED;
			end else if (it.category == CAT_PAUSE) begin
				if (pause_streak != PAUSE_MAX)
					pause_streak++;
				if (pause_streak >= close_setting)
					doors_shut = 1'b1;
				r.status = ST_PAUSE;
			end else begin
				cls = int'(it.category) - 1;
				pause_streak = '0;
				if (held < lim && class_depth[cls] < MAX_ENTRIES) begin
					class_slot[cls][(class_head[cls] + class_depth[cls]) % MAX_ENTRIES] =
						it.duration;
					class_depth[cls]++;
					r.status = ST_ACCEPTED;
				end else begin
					r.status = ST_DROPPED;
				end
			end
		end else begin
			for (int k = NUM_CLASSES - 1; k >= 0; k--)
				if (class_depth[k] != 0)
					cls = k;
			if (cls < 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.served_duration = class_slot[cls][class_head[cls]];
				class_head[cls] = (class_head[cls] + 1) % MAX_ENTRIES;
				class_depth[cls]--;
				if (served_tally[cls] != '1)
					served_tally[cls]++;
				t = int'(time_tally[cls]) + int'(r.served_duration);
				time_tally[cls] = STIME_W'((t > TIME_CAP) ? TIME_CAP : t);
				r.served_category = CAT_W'(cls + 1);
				r.class_served_count = served_tally[cls];
				r.class_service_time = time_tally[cls];
				r.status = ST_SERVED;
			end
		end
		r.occupancy = OCC_W'(class_depth[0] + class_depth[1] + class_depth[2]);
		r.arrivals_closed = doors_shut;
		return r;
	endfunction

	function automatic req_t random_item(int arrive_pct, bit allow_close, bit last);
		req_t it;
		it.op = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_SERVE;
		it.category = CAT_W'($urandom_range(3));
		it.duration = DUR_W'($urandom_range(7));
		if (!allow_close) begin
			if (last) begin
				it.op = OP_ARRIVE;
				if (it.category == CAT_PAUSE)
					it.category = CAT_W'($urandom_range(3, 1));
			end else if (it.op == OP_ARRIVE && it.category == CAT_PAUSE &&
					int'(pause_streak) + 1 >= int'(close_setting)) begin
				it.category = CAT_W'($urandom_range(3, 1));
			end
		end
		return it;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic wait_for_outcomes();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_item(req_t it, bit typed, rsp_t want);
		rsp_t outcome;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= it.op;
		req_ch.category <= it.category;
		req_ch.duration <= it.duration;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		outcome = queue_outcome(it);
		pending_outcomes.push_back(typed ? want : outcome);
	endtask

	task automatic apply_settings(logic [CAP_W-1:0] cap, logic [CLOSE_W-1:0] close,
			bit poke_spare);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		int                    writes;
		idx[0] = REG_CAPACITY;
		val[0] = cap;
		idx[1] = REG_CLOSING;
		val[1] = CFG_DATA_W'(close);
		idx[2] = SPARE_INDEX;
		val[2] = CFG_DATA_W'($urandom_range(63));
		writes = poke_spare ? 3 : 2;
		wait_for_outcomes();
		for (int k = 0; k < writes; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[k];
			cfg_ch.data <= val[k];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		cap_setting = cap;
		close_setting = close;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result transfer with no outcome pending");
				mismatches++;
			end else begin
				oldest_outcome = pending_outcomes.pop_front();
				check_field("status", oldest_outcome.status, rsp_ch.status);
				check_field("served_category", oldest_outcome.served_category,
					rsp_ch.served_category);
				check_field("served_duration", oldest_outcome.served_duration,
					rsp_ch.served_duration);
				check_field("occupancy", oldest_outcome.occupancy, rsp_ch.occupancy);
				check_field("arrivals_closed", oldest_outcome.arrivals_closed,
					rsp_ch.arrivals_closed);
				check_field("class_served_count", oldest_outcome.class_served_count,
					rsp_ch.class_served_count);
				check_field("class_service_time", oldest_outcome.class_service_time,
					rsp_ch.class_service_time);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("three_class_priority_queue_unit_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req_t        item;
		rsp_t        want;
		script_row_t row;
		phase_t      ph;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ARRIVE;
		req_ch.category = CAT_PAUSE;
		req_ch.duration = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_CAPACITY;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (SCRIPT[i]) begin
			row = SCRIPT[i];
			if (row.is_cfg) begin
				apply_settings(row.cap_val, row.close_val, 1'b0);
			end else begin
				item.op = row.op;
				item.category = row.cat;
				item.duration = row.dur;
				want = '0;
				want.status = row.st;
				want.occupancy = row.occ;
				send_item(item, row.typed, want);
			end
		end

		foreach (PHASES[p]) begin
			ph = PHASES[p];
			apply_settings(ph.cap, ph.close, p == 4);
			send_idle_pct = ph.send_idle;
			stall_pct <= ph.stall;
			if (ph.hold)
				hold_token <= hold_token + 1;
			for (int n = 0; n < ph.items; n++)
				send_item(random_item(ph.arrive, ph.allow_close, n == ph.items - 1),
					1'b0, '0);
		end

		apply_settings(cap_setting, '0, 1'b0);
		for (int n = 0; n < 8; n++)
			send_item(random_item(50, 1'b1, 1'b0), 1'b0, '0);
		wait_for_outcomes();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("three_class_priority_queue_unit_tb passed");
		end else begin
			$display("three_class_priority_queue_unit_tb failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/tcpq_pkg.sv
design/tcpq_if.sv
design/tcpq_class_fifo.sv
design/three_class_priority_queue_unit.sv
bench/three_class_priority_queue_unit_tb.sv
